/* rtl/closest_point_on_triangle_core_defines.svh */
// Assertion macros shared by the closest point core checker.
// Needs aclk and aresetn in the scope where a macro is used.
`ifndef CLOSEST_POINT_ON_TRIANGLE_CORE_DEFINES_SVH
`define CLOSEST_POINT_ON_TRIANGLE_CORE_DEFINES_SVH

// same-cycle implication, masked during reset
`define CPT_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("closest point core check failed");

// next-cycle implication, masked during reset
`define CPT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("closest point core check failed");

// property that must hold in the cycle after reset is seen
`define CPT_ASSERT_RESET(lbl, cons) \
    lbl: assert property (@(posedge aclk) (!aresetn) |=> (cons)) \
        else $error("closest point core reset check failed");

`endif

/* rtl/cpt_pkg.sv */
// Package for the closest point on triangle core: defaults and region codes.
// No dependencies; used by the core and its checker.
`default_nettype none

package cpt_pkg;

    // default coordinate width (signed fixed point, Q8.8 at 16 bits)
    localparam int COORD_WIDTH_DEF = 16;

    // chunk width used to split wide factors into partial products
    localparam int CHUNK_BITS = 24;

    // Voronoi region of the closest point
    typedef enum logic [2:0] {
        REG_A    = 3'd0,
        REG_B    = 3'd1,
        REG_C    = 3'd2,
        REG_AB   = 3'd3,
        REG_BC   = 3'd4,
        REG_CA   = 3'd5,
        REG_FACE = 3'd6
    } region_t;

endpackage

`default_nettype wire

/* rtl/closest_point_on_triangle_core.sv */
// Closest point on a triangle to a query point: a fully pipelined core.
// Depends on cpt_pkg (region codes, chunk width, defaults).
//
// The core takes one item (query point P and vertices A, B, C, signed fixed
// point) per clock while the output is not stalled and returns the closest
// point on the triangle, its Voronoi region (vertex, edge or face) and a
// flag for a degenerate face. The pipeline has nine stages of exact dot,
// cross and triple products, region selection and numerator build,
// then a restoring divider that settles one quotient bit per stage over
// COORD_WIDTH + 3 stages, then the saturating output register. Quotients
// whose magnitude reaches 2^(COORD_WIDTH+3) are caught up front and
// saturate. Each stage holds its own valid bit and stalls only when the
// stage after it is stalled too, so bubbles close up under back-pressure.
`default_nettype none

module closest_point_on_triangle_core
    import cpt_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           s_valid,
    output logic                          s_ready,
    input  wire signed [COORD_WIDTH-1:0]  s_point_x,
    input  wire signed [COORD_WIDTH-1:0]  s_point_y,
    input  wire signed [COORD_WIDTH-1:0]  s_point_z,
    input  wire signed [COORD_WIDTH-1:0]  s_vert_a_x,
    input  wire signed [COORD_WIDTH-1:0]  s_vert_a_y,
    input  wire signed [COORD_WIDTH-1:0]  s_vert_a_z,
    input  wire signed [COORD_WIDTH-1:0]  s_vert_b_x,
    input  wire signed [COORD_WIDTH-1:0]  s_vert_b_y,
    input  wire signed [COORD_WIDTH-1:0]  s_vert_b_z,
    input  wire signed [COORD_WIDTH-1:0]  s_vert_c_x,
    input  wire signed [COORD_WIDTH-1:0]  s_vert_c_y,
    input  wire signed [COORD_WIDTH-1:0]  s_vert_c_z,
    output logic                          m_valid,
    input  wire                           m_ready,
    output logic signed [COORD_WIDTH-1:0] m_near_x,
    output logic signed [COORD_WIDTH-1:0] m_near_y,
    output logic signed [COORD_WIDTH-1:0] m_near_z,
    output logic [2:0]                    m_region,
    output logic                          m_degenerate
);

    // widths of the exact intermediate values
    localparam int W    = COORD_WIDTH;
    localparam int D    = W + 1;            // coordinate difference
    localparam int DW   = 2 * D + 2;        // dot product
    localparam int CW   = 2 * D + 1;        // cross product component
    localparam int LO   = (CW + 1) / 2;     // low split of a cross component
    localparam int HI   = CW - LO;
    localparam int TW   = 2 * CW + 2;       // triple product
    localparam int DNW  = TW + 2;           // divisor
    localparam int CH   = CHUNK_BITS;
    localparam int NC   = (TW + CH - 1) / CH;
    localparam int FXW  = NC * CH;
    localparam int PPW  = CH + D + 1;       // partial product
    localparam int NW   = FXW + D + 2;      // dividend
    localparam int QB   = W + 3;            // quotient bits kept
    localparam int RW0  = DNW + QB + 1;
    localparam int RW   = (NW > RW0) ? NW : RW0;
    localparam int NST  = QB + 10;          // register stages
    localparam int SBW  = 3 * W + 5;        // sideband: bases, region, flags

    // dot product slots
    localparam int DT_SN = 0;
    localparam int DT_SD = 1;
    localparam int DT_TN = 2;
    localparam int DT_TD = 3;
    localparam int DT_UN = 4;
    localparam int DT_UD = 5;

    localparam logic signed [QB+1:0] SAT_HI = (QB+2)'((64'sd1 <<< (W - 1)) - 64'sd1);
    localparam logic signed [QB+1:0] SAT_LO = -SAT_HI - (QB+2)'(1);

    function automatic logic signed [DW-1:0] dot_f(
        input logic signed [D-1:0] x0, x1, x2, y0, y1, y2
    );
        logic signed [2*D-1:0] p0, p1, p2;
        p0 = x0 * y0;
        p1 = x1 * y1;
        p2 = x2 * y2;
        return DW'(p0) + DW'(p1) + DW'(p2);
    endfunction

    // u*v - x*y, exact
    function automatic logic signed [CW-1:0] cross_f(
        input logic signed [D-1:0] u, v, x, y
    );
        logic signed [2*D-1:0] p0, p1;
        p0 = u * v;
        p1 = x * y;
        return CW'(p0) - CW'(p1);
    endfunction

    // ---------------- flow control ----------------
    logic [NST-1:0] vld_reg, vld_next;
    logic [NST-1:0] adv;

    // a stage loads when it is empty or the stage after it moves
    always_comb begin
        adv[NST-1] = ~vld_reg[NST-1] | m_ready;
        for (int i = NST - 2; i >= 0; i--) begin
            adv[i] = ~vld_reg[i] | adv[i+1];
        end
        vld_next = vld_reg;
        if (adv[0]) begin
            vld_next[0] = s_valid;
        end
        for (int i = 1; i < NST; i++) begin
            if (adv[i]) begin
                vld_next[i] = vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_ready = adv[0];
    assign m_valid = vld_reg[NST-1];

    // ---------------- stage 0: differences ----------------
    logic signed [W-1:0] vtx_in [3][3];
    logic signed [W-1:0] pnt_in [3];
    logic signed [W-1:0] vtx0_reg [3][3];
    logic signed [D-1:0] edge0_next [3][3], edge0_reg [3][3];   // ab, ac, bc
    logic signed [D-1:0] rel0_next [3][3], rel0_reg [3][3];     // a-p, b-p, c-p

    always_comb begin
        pnt_in[0]    = s_point_x;
        pnt_in[1]    = s_point_y;
        pnt_in[2]    = s_point_z;
        vtx_in[0][0] = s_vert_a_x;
        vtx_in[0][1] = s_vert_a_y;
        vtx_in[0][2] = s_vert_a_z;
        vtx_in[1][0] = s_vert_b_x;
        vtx_in[1][1] = s_vert_b_y;
        vtx_in[1][2] = s_vert_b_z;
        vtx_in[2][0] = s_vert_c_x;
        vtx_in[2][1] = s_vert_c_y;
        vtx_in[2][2] = s_vert_c_z;
        for (int k = 0; k < 3; k++) begin
            edge0_next[0][k] = D'(vtx_in[1][k]) - D'(vtx_in[0][k]);
            edge0_next[1][k] = D'(vtx_in[2][k]) - D'(vtx_in[0][k]);
            edge0_next[2][k] = D'(vtx_in[2][k]) - D'(vtx_in[1][k]);
            for (int v = 0; v < 3; v++) begin
                rel0_next[v][k] = D'(vtx_in[v][k]) - D'(pnt_in[k]);
            end
        end
    end

    // ---------------- stage 1: dots and crosses ----------------
    logic signed [W-1:0]  vtx1_reg [3][3];
    logic signed [D-1:0]  edge1_reg [3][3];
    logic signed [DW-1:0] dot1_next [6], dot1_reg [6];
    logic signed [CW-1:0] nrm1_next [3], nrm1_reg [3];
    logic signed [CW-1:0] crs1_next [3][3], crs1_reg [3][3];   // ap x bp, bp x cp, cp x ap

    always_comb begin
        dot1_next[DT_SN] = -dot_f(rel0_reg[0][0], rel0_reg[0][1], rel0_reg[0][2],
                                  edge0_reg[0][0], edge0_reg[0][1], edge0_reg[0][2]);
        dot1_next[DT_SD] = dot_f(rel0_reg[1][0], rel0_reg[1][1], rel0_reg[1][2],
                                 edge0_reg[0][0], edge0_reg[0][1], edge0_reg[0][2]);
        dot1_next[DT_TN] = -dot_f(rel0_reg[0][0], rel0_reg[0][1], rel0_reg[0][2],
                                  edge0_reg[1][0], edge0_reg[1][1], edge0_reg[1][2]);
        dot1_next[DT_TD] = dot_f(rel0_reg[2][0], rel0_reg[2][1], rel0_reg[2][2],
                                 edge0_reg[1][0], edge0_reg[1][1], edge0_reg[1][2]);
        dot1_next[DT_UN] = -dot_f(rel0_reg[1][0], rel0_reg[1][1], rel0_reg[1][2],
                                  edge0_reg[2][0], edge0_reg[2][1], edge0_reg[2][2]);
        dot1_next[DT_UD] = dot_f(rel0_reg[2][0], rel0_reg[2][1], rel0_reg[2][2],
                                 edge0_reg[2][0], edge0_reg[2][1], edge0_reg[2][2]);
        // face normal ab x ac
        nrm1_next[0] = cross_f(edge0_reg[0][1], edge0_reg[1][2],
                               edge0_reg[0][2], edge0_reg[1][1]);
        nrm1_next[1] = cross_f(edge0_reg[0][2], edge0_reg[1][0],
                               edge0_reg[0][0], edge0_reg[1][2]);
        nrm1_next[2] = cross_f(edge0_reg[0][0], edge0_reg[1][1],
                               edge0_reg[0][1], edge0_reg[1][0]);
        for (int t = 0; t < 3; t++) begin
            crs1_next[t][0] = cross_f(rel0_reg[t][1], rel0_reg[(t+1)%3][2],
                                      rel0_reg[t][2], rel0_reg[(t+1)%3][1]);
            crs1_next[t][1] = cross_f(rel0_reg[t][2], rel0_reg[(t+1)%3][0],
                                      rel0_reg[t][0], rel0_reg[(t+1)%3][2]);
            crs1_next[t][2] = cross_f(rel0_reg[t][0], rel0_reg[(t+1)%3][1],
                                      rel0_reg[t][1], rel0_reg[(t+1)%3][0]);
        end
    end

    // ---------------- stage 2: split triple products ----------------
    logic signed [W-1:0]    vtx2_reg [3][3];
    logic signed [D-1:0]    edge2_reg [3][3];
    logic signed [DW-1:0]   dot2_reg [6];
    logic signed [CW+LO:0]  plo2_next [3][3], plo2_reg [3][3];
    logic signed [CW+HI-1:0] phi2_next [3][3], phi2_reg [3][3];

    always_comb begin
        logic signed [LO:0]   xlo;
        logic signed [HI-1:0] xhi;
        for (int t = 0; t < 3; t++) begin
            for (int k = 0; k < 3; k++) begin
                xlo = $signed({1'b0, crs1_reg[t][k][LO-1:0]});
                xhi = $signed(crs1_reg[t][k][CW-1:LO]);
                plo2_next[t][k] = nrm1_reg[k] * xlo;
                phi2_next[t][k] = nrm1_reg[k] * xhi;
            end
        end
    end

    // ---------------- stage 3: triple product sums ----------------
    logic signed [W-1:0]  vtx3_reg [3][3];
    logic signed [D-1:0]  edge3_reg [3][3];
    logic signed [DW-1:0] dot3_reg [6];
    logic signed [TW-1:0] tri3_next [3], tri3_reg [3];      // vc, va, vb

    always_comb begin
        for (int t = 0; t < 3; t++) begin
            tri3_next[t] = '0;
            for (int k = 0; k < 3; k++) begin
                tri3_next[t] = tri3_next[t] + (TW'(phi2_reg[t][k]) <<< LO)
                             + TW'(plo2_reg[t][k]);
            end
        end
    end

    // ---------------- stage 4: region and operand select ----------------
    logic [SBW-1:0]        sb4_next, sb4_reg;
    logic signed [DNW-1:0] den4_next, den4_reg;
    logic signed [TW-1:0]  f14_next, f14_reg, f24_next, f24_reg;
    logic signed [D-1:0]   d14_next [3], d14_reg [3], d24_next [3], d24_reg [3];

    always_comb begin
        logic signed [DW-1:0] sn, sd, tn, td, un, ud;
        logic signed [TW-1:0] vcv, vav, vbv;
        logic signed [DNW-1:0] dsum;
        logic sn_le, sd_le, tn_le, td_le, un_le, ud_le, vc_le, va_le, vb_le;
        region_t rg;
        logic degen, zq;
        logic [1:0] bsel;
        sn  = dot3_reg[DT_SN];
        sd  = dot3_reg[DT_SD];
        tn  = dot3_reg[DT_TN];
        td  = dot3_reg[DT_TD];
        un  = dot3_reg[DT_UN];
        ud  = dot3_reg[DT_UD];
        vcv = tri3_reg[0];
        vav = tri3_reg[1];
        vbv = tri3_reg[2];
        sn_le = sn[DW-1] | (sn == '0);
        sd_le = sd[DW-1] | (sd == '0);
        tn_le = tn[DW-1] | (tn == '0);
        td_le = td[DW-1] | (td == '0);
        un_le = un[DW-1] | (un == '0);
        ud_le = ud[DW-1] | (ud == '0);
        vc_le = vcv[TW-1] | (vcv == '0);
        va_le = vav[TW-1] | (vav == '0);
        vb_le = vbv[TW-1] | (vbv == '0);
        dsum  = DNW'(vav) + DNW'(vbv) + DNW'(vcv);

        rg        = REG_FACE;
        degen     = 1'b0;
        zq        = 1'b1;
        bsel      = 2'd0;
        f14_next  = '0;
        f24_next  = '0;
        den4_next = DNW'(1);
        for (int k = 0; k < 3; k++) begin
            d14_next[k] = edge3_reg[0][k];
            d24_next[k] = edge3_reg[1][k];
        end

        if (sn_le && tn_le) begin
            rg = REG_A;
        end else if (sd_le && un_le) begin
            rg   = REG_B;
            bsel = 2'd1;
        end else if (td_le && ud_le) begin
            rg   = REG_C;
            bsel = 2'd2;
        end else if (vc_le && !sn[DW-1] && !sd[DW-1]) begin
            rg        = REG_AB;
            f14_next  = TW'(sn);
            den4_next = DNW'(sn) + DNW'(sd);
            zq        = (den4_next == '0);
        end else if (va_le && !un[DW-1] && !ud[DW-1]) begin
            rg        = REG_BC;
            bsel      = 2'd1;
            f14_next  = TW'(un);
            den4_next = DNW'(un) + DNW'(ud);
            zq        = (den4_next == '0);
            for (int k = 0; k < 3; k++) begin
                d14_next[k] = edge3_reg[2][k];
            end
        end else if (vb_le && !tn[DW-1] && !td[DW-1]) begin
            rg        = REG_CA;
            f14_next  = TW'(tn);
            den4_next = DNW'(tn) + DNW'(td);
            zq        = (den4_next == '0);
            for (int k = 0; k < 3; k++) begin
                d14_next[k] = edge3_reg[1][k];
            end
        end else begin
            // face: weights vb on ab and vc on ac over va + vb + vc
            rg        = REG_FACE;
            f14_next  = vbv;
            f24_next  = vcv;
            den4_next = dsum;
            zq        = (dsum == '0);
            degen     = (dsum == '0);
        end

        sb4_next = {vtx3_reg[bsel][2], vtx3_reg[bsel][1], vtx3_reg[bsel][0],
                    rg, degen, zq};
    end

    // ---------------- stage 5: partial products ----------------
    logic [SBW-1:0]        sb5_reg;
    logic signed [DNW-1:0] den5_reg;
    logic signed [PPW-1:0] pp15_next [3][NC], pp15_reg [3][NC];
    logic signed [PPW-1:0] pp25_next [3][NC], pp25_reg [3][NC];

    always_comb begin
        logic signed [FXW-1:0] fx1, fx2;
        logic signed [CH:0]    cs1, cs2;
        fx1 = FXW'(f14_reg);
        fx2 = FXW'(f24_reg);
        for (int j = 0; j < NC; j++) begin
            if (j == NC - 1) begin
                cs1 = (CH+1)'($signed(fx1[CH*j +: CH]));
                cs2 = (CH+1)'($signed(fx2[CH*j +: CH]));
            end else begin
                cs1 = $signed({1'b0, fx1[CH*j +: CH]});
                cs2 = $signed({1'b0, fx2[CH*j +: CH]});
            end
            for (int k = 0; k < 3; k++) begin
                pp15_next[k][j] = cs1 * d14_reg[k];
                pp25_next[k][j] = cs2 * d24_reg[k];
            end
        end
    end

    // ---------------- stage 6: dividend sums ----------------
    logic [SBW-1:0]        sb6_reg;
    logic signed [DNW-1:0] den6_reg;
    logic signed [NW-1:0]  num6_next [3], num6_reg [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            num6_next[k] = '0;
            for (int j = 0; j < NC; j++) begin
                num6_next[k] = num6_next[k] + (NW'(pp15_reg[k][j]) <<< (CH * j))
                             + (NW'(pp25_reg[k][j]) <<< (CH * j));
            end
        end
    end

    // ---------------- stage 7: magnitudes and quotient signs ----------------
    logic [SBW-1:0] sb7_reg;
    logic [RW-1:0]  nab7_next [3], nab7_reg [3];
    logic [RW-1:0]  dab7_next, dab7_reg;
    logic [2:0]     neg7_next, neg7_reg;

    always_comb begin
        logic [NW-1:0]  nmag;
        logic [DNW-1:0] dmag;
        dmag      = den6_reg[DNW-1] ? DNW'(-den6_reg) : DNW'(den6_reg);
        dab7_next = RW'(dmag);
        for (int k = 0; k < 3; k++) begin
            nmag         = num6_reg[k][NW-1] ? NW'(-num6_reg[k]) : NW'(num6_reg[k]);
            nab7_next[k] = RW'(nmag);
            neg7_next[k] = num6_reg[k][NW-1] ^ den6_reg[DNW-1];
        end
    end

    // ---------------- stage 8 and divider steps ----------------
    // index 0 is loaded by stage 8, index i+1 by divider step i
    logic [RW-1:0]  rem_next [QB+1][3], rem_reg [QB+1][3];
    logic [QB-1:0]  quo_next [QB+1][3], quo_reg [QB+1][3];
    logic [RW-1:0]  dv_reg [QB+1];
    logic [SBW-1:0] sb_reg [QB+1];
    logic [2:0]     neg_reg [QB+1];
    logic [2:0]     ovf_next, ovf_reg [QB+1];

    always_comb begin
        logic [RW-1:0] sh;
        // quotients past the kept range saturate the result
        sh = dab7_reg << QB;
        for (int k = 0; k < 3; k++) begin
            ovf_next[k]    = (nab7_reg[k] >= sh);
            rem_next[0][k] = nab7_reg[k];
            quo_next[0][k] = '0;
        end
        // restoring division, most significant quotient bit first
        for (int i = 0; i < QB; i++) begin
            sh = dv_reg[i] << (QB - 1 - i);
            for (int k = 0; k < 3; k++) begin
                if (rem_reg[i][k] >= sh) begin
                    rem_next[i+1][k] = rem_reg[i][k] - sh;
                    quo_next[i+1][k] = quo_reg[i][k] | (QB'(1) << (QB - 1 - i));
                end else begin
                    rem_next[i+1][k] = rem_reg[i][k];
                    quo_next[i+1][k] = quo_reg[i][k];
                end
            end
        end
    end

    // ---------------- output stage: add, saturate ----------------
    logic signed [W-1:0] near_next [3], near_reg [3];
    logic [2:0]          region_reg;
    logic                degen_reg;

    always_comb begin
        logic signed [QB:0]   qs;
        logic signed [QB+1:0] sum;
        logic [SBW-1:0]       sb;
        sb = sb_reg[QB];
        for (int k = 0; k < 3; k++) begin
            qs  = $signed({1'b0, quo_reg[QB][k]});
            if (neg_reg[QB][k]) begin
                qs = -qs;
            end
            if (sb[0]) begin
                qs = '0;
            end
            sum = (QB+2)'($signed(sb[5+W*k +: W])) + (QB+2)'(qs);
            if (ovf_reg[QB][k] && !sb[0]) begin
                sum = neg_reg[QB][k] ? SAT_LO : SAT_HI;
            end else if (sum > SAT_HI) begin
                sum = SAT_HI;
            end else if (sum < SAT_LO) begin
                sum = SAT_LO;
            end
            near_next[k] = W'(sum);
        end
    end

    // ---------------- pipeline payload registers ----------------
    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            for (int k = 0; k < 3; k++) begin
                for (int v = 0; v < 3; v++) begin
                    vtx0_reg[v][k]  <= vtx_in[v][k];
                    edge0_reg[v][k] <= edge0_next[v][k];
                    rel0_reg[v][k]  <= rel0_next[v][k];
                end
            end
        end
        if (adv[1]) begin
            vtx1_reg  <= vtx0_reg;
            edge1_reg <= edge0_reg;
            dot1_reg  <= dot1_next;
            nrm1_reg  <= nrm1_next;
            crs1_reg  <= crs1_next;
        end
        if (adv[2]) begin
            vtx2_reg  <= vtx1_reg;
            edge2_reg <= edge1_reg;
            dot2_reg  <= dot1_reg;
            plo2_reg  <= plo2_next;
            phi2_reg  <= phi2_next;
        end
        if (adv[3]) begin
            vtx3_reg  <= vtx2_reg;
            edge3_reg <= edge2_reg;
            dot3_reg  <= dot2_reg;
            tri3_reg  <= tri3_next;
        end
        if (adv[4]) begin
            sb4_reg  <= sb4_next;
            den4_reg <= den4_next;
            f14_reg  <= f14_next;
            f24_reg  <= f24_next;
            d14_reg  <= d14_next;
            d24_reg  <= d24_next;
        end
        if (adv[5]) begin
            sb5_reg  <= sb4_reg;
            den5_reg <= den4_reg;
            pp15_reg <= pp15_next;
            pp25_reg <= pp25_next;
        end
        if (adv[6]) begin
            sb6_reg  <= sb5_reg;
            den6_reg <= den5_reg;
            num6_reg <= num6_next;
        end
        if (adv[7]) begin
            sb7_reg  <= sb6_reg;
            nab7_reg <= nab7_next;
            dab7_reg <= dab7_next;
            neg7_reg <= neg7_next;
        end
        if (adv[8]) begin
            rem_reg[0] <= rem_next[0];
            quo_reg[0] <= quo_next[0];
            dv_reg[0]  <= dab7_reg;
            sb_reg[0]  <= sb7_reg;
            neg_reg[0] <= neg7_reg;
            ovf_reg[0] <= ovf_next;
        end
        for (int i = 0; i < QB; i++) begin
            if (adv[9+i]) begin
                rem_reg[i+1] <= rem_next[i+1];
                quo_reg[i+1] <= quo_next[i+1];
                dv_reg[i+1]  <= dv_reg[i];
                sb_reg[i+1]  <= sb_reg[i];
                neg_reg[i+1] <= neg_reg[i];
                ovf_reg[i+1] <= ovf_reg[i];
            end
        end
        if (adv[NST-1]) begin
            near_reg   <= near_next;
            region_reg <= sb_reg[QB][4:2];
            degen_reg  <= sb_reg[QB][1];
        end
    end

    assign m_near_x     = near_reg[0];
    assign m_near_y     = near_reg[1];
    assign m_near_z     = near_reg[2];
    assign m_region     = region_reg;
    assign m_degenerate = degen_reg;

endmodule

`default_nettype wire

/* rtl/cpt_checker.sv */
// Port-level checker for closest_point_on_triangle_core, bound to the top level.
// Depends on cpt_pkg and closest_point_on_triangle_core_defines.svh.
`default_nettype none
`include "closest_point_on_triangle_core_defines.svh"

module cpt_checker
    import cpt_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input wire                          aclk,
    input wire                          aresetn,
    input wire                          s_valid,
    input wire                          s_ready,
    input wire                          m_valid,
    input wire                          m_ready,
    input wire signed [COORD_WIDTH-1:0] m_near_x,
    input wire signed [COORD_WIDTH-1:0] m_near_y,
    input wire signed [COORD_WIDTH-1:0] m_near_z,
    input wire [2:0]                    m_region,
    input wire                          m_degenerate
);

    // items accepted but not yet delivered
    logic [7:0] cnt_reg, cnt_next;

    // whole result payload, for the hold check
    logic [3*COORD_WIDTH+3:0] m_payload;

    assign m_payload = {m_near_x, m_near_y, m_near_z, m_region, m_degenerate};

    always_comb begin
        cnt_next = cnt_reg;
        if (s_valid && s_ready) begin
            cnt_next = cnt_next + 8'd1;
        end
        if (m_valid && m_ready) begin
            cnt_next = cnt_next - 8'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    `CPT_ASSERT_RESET(a_reset_empty, !m_valid)
    `CPT_ASSERT_SAME(a_no_phantom_item, m_valid, cnt_reg != 8'd0)
    `CPT_ASSERT_SAME(a_degen_is_face, m_valid && m_degenerate, m_region == REG_FACE)
    `CPT_ASSERT_NEXT(a_stall_holds, m_valid && !m_ready, m_valid && $stable(m_payload))

endmodule

bind closest_point_on_triangle_core cpt_checker #(.COORD_WIDTH(COORD_WIDTH)) u_cpt_checker (.*);

`default_nettype wire
